[sv/hrwf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package hrwf_pkg;

  localparam int SAMPLE_W   = 8;
  localparam int QUO_W      = 8;
  localparam int COUNT_W    = 7;
  localparam int RECENT_LEN = 10;
  localparam int TRIM_LOW   = 10;
  localparam int TRIM_HIGH  = 11;
  localparam int RECENT_N_W = $clog2(RECENT_LEN + 1);
  localparam int DIV_STEPS  = QUO_W / 2;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [1:0] {
    OP_HOLD = 2'b00,
    OP_DEL  = 2'b01,
    OP_INS  = 2'b10
  } cell_op_t;

  // broadcast to every cell of the sorted row
  typedef struct packed {
    cell_op_t op;
    sample_t  key;
  } cell_ctrl_t;

endpackage

`default_nettype wire

[sv/heart_rate_window_filter.sv]
// Heart-rate window filter.
// Input channel: sample (8 bit bpm) and sensor_active, qualified by in_valid;
// the block raises in_stall while it works on an item. Output channel:
// max_rate, recent_average, trimmed_mean and stored_count, qualified by
// out_valid and held while out_stall is high.
// Each accepted sample gives exactly one result. The window sits twice: a
// shift line in arrival order and a row of sorted cells that is updated by
// one delete pass and one insert pass. The trimmed-mean sum is kept up to
// date from a few fixed taps of the sorted row, the recent sum from the
// arrival line; a radix-4 divider gives the recent mean, the
// trimmed mean is divided by its fixed length through a reciprocal multiply.
// An item passes the delete pass, the insert pass and the divider before its
// result is registered; in_stall holds off new samples until that is done.
// The output register lets the next sample be taken while a result waits;
// if the receiver stalls for long the block holds its finished result and
// stalls the input until the output register frees.
// Reset (rst, synchronous) clears the window to zero, the fill count and the
// running maximum; in_stall is low right after reset.
`timescale 1ns / 1ps
`default_nettype none

module heart_rate_window_filter #(
  parameter int WINDOW_SIZE = 64
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          in_valid,
  output logic                         in_stall,
  input  wire  [7:0]                   sample,
  input  wire                          sensor_active,
  output logic                         out_valid,
  input  wire                          out_stall,
  output logic [7:0]                   max_rate,
  output logic [7:0]                   recent_average,
  output logic [7:0]                   trimmed_mean,
  output logic [hrwf_pkg::COUNT_W-1:0] stored_count
);
  import hrwf_pkg::*;

  localparam int CNT_W   = $clog2(WINDOW_SIZE + 1);
  localparam int MID_LEN = WINDOW_SIZE - TRIM_LOW - TRIM_HIGH;
  localparam int MID_W   = $clog2(MID_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int DEN_W   = $clog2(MID_LEN + 1);
  localparam int RSUM_W  = $clog2(RECENT_LEN * ((1 << SAMPLE_W) - 1) + 1);
  localparam int HI_TAP  = WINDOW_SIZE - TRIM_HIGH - 1;
  // exact floor division by MID_LEN for every numerator below 2**MID_W
  localparam int TRIM_SHIFT = MID_W + DEN_W;
  localparam int TRIM_RECIP = ((1 << TRIM_SHIFT) + MID_LEN - 1) / MID_LEN;
  localparam int RECIP_W    = $clog2(TRIM_RECIP + 1);
  localparam int PROD_W     = MID_W + RECIP_W;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_DEL    = 6'b000010,
    ST_INS    = 6'b000100,
    ST_DSTART = 6'b001000,
    ST_DWAIT  = 6'b010000,
    ST_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  sample_t               smp;
  logic                  act;
  logic                  store;
  sample_t               arr [WINDOW_SIZE];
  sample_t               sv  [WINDOW_SIZE];
  logic [CNT_W-1:0]      fill;
  sample_t               rmax;
  logic [RSUM_W-1:0]     rsum;
  logic [MID_W-1:0]      mid, mid_del, mid_ins;
  logic                  store_c;
  logic [RECENT_N_W-1:0] rn;
  cell_ctrl_t            cell_ctrl;
  logic                  load_out;
  logic                  div_start;
  logic                  rdiv_done;
  logic [QUO_W-1:0]      rquo, tquo;
  logic [PROD_W-1:0]     tprod;

  assign in_stall  = (state != ST_IDLE);
  assign store_c   = (fill != '0) || act;
  assign div_start = (state == ST_DSTART);
  assign load_out  = (state == ST_DONE) && (!out_valid || !out_stall);
  assign rn        = (fill < CNT_W'(RECENT_LEN)) ? RECENT_N_W'(fill)
                                                 : RECENT_N_W'(RECENT_LEN);
  assign tprod     = PROD_W'(mid) * PROD_W'(TRIM_RECIP);
  assign tquo      = QUO_W'(tprod >> TRIM_SHIFT);

  // middle-sum update from the sorted row, before and after the delete pass
  always_comb begin
    if (sv[TRIM_LOW-1] >= arr[WINDOW_SIZE-1]) begin
      mid_del = mid - MID_W'(sv[TRIM_LOW]) + MID_W'(sv[HI_TAP+1]);
    end else if (sv[HI_TAP] >= arr[WINDOW_SIZE-1]) begin
      mid_del = mid - MID_W'(arr[WINDOW_SIZE-1]) + MID_W'(sv[HI_TAP+1]);
    end else begin
      mid_del = mid;
    end
    if (sv[TRIM_LOW-1] > smp) begin
      mid_ins = mid + MID_W'(sv[TRIM_LOW-1]) - MID_W'(sv[HI_TAP]);
    end else if (sv[HI_TAP] > smp) begin
      mid_ins = mid + MID_W'(smp) - MID_W'(sv[HI_TAP]);
    end else begin
      mid_ins = mid;
    end
  end

  always_comb begin
    cell_ctrl.op  = OP_HOLD;
    cell_ctrl.key = smp;
    if (state == ST_DEL && store_c) begin
      cell_ctrl.op  = OP_DEL;
      cell_ctrl.key = arr[WINDOW_SIZE-1];
    end else if (state == ST_INS && store) begin
      cell_ctrl.op  = OP_INS;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_DEL;
      ST_DEL:    state_next = ST_INS;
      ST_INS:    state_next = ST_DSTART;
      ST_DSTART: state_next = ST_DWAIT;
      ST_DWAIT:  if (rdiv_done) state_next = ST_DONE;
      ST_DONE:   if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      store     <= 1'b0;
      fill      <= '0;
      rmax      <= '0;
      rsum      <= '0;
      mid       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_DEL) begin
        store <= store_c;
        if (smp > rmax) rmax <= smp;
        if (store_c) begin
          rsum <= rsum + RSUM_W'(smp) - RSUM_W'(arr[RECENT_LEN-1]);
          mid  <= mid_del;
          if (fill < CNT_W'(WINDOW_SIZE)) fill <= fill + 1'b1;
        end
      end
      if (state == ST_INS && store) mid <= mid_ins;
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // arrival-order line, newest at the head; unfilled entries stay zero
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < WINDOW_SIZE; i++) arr[i] <= '0;
    end else if (state == ST_DEL && store_c) begin
      arr[0] <= smp;
      for (int i = 1; i < WINDOW_SIZE; i++) arr[i] <= arr[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      smp <= sample;
      act <= sensor_active;
    end
    if (load_out) begin
      max_rate       <= rmax;
      recent_average <= (fill == '0) ? '0 : rquo;
      trimmed_mean   <= tquo;
      stored_count   <= COUNT_W'(fill);
    end
  end

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    sample_t pv, nv;
    if (i == 0) begin : g_first
      assign pv = '0;
    end else begin : g_mid_prev
      assign pv = sv[i-1];
    end
    if (i == WINDOW_SIZE - 1) begin : g_last
      assign nv = '1;
    end else begin : g_mid_next
      assign nv = sv[i+1];
    end
    hrwf_sort_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (cell_ctrl),
      .prev_val (pv),
      .next_val (nv),
      .val      (sv[i])
    );
  end

  hrwf_div #(
    .NUM_W (RSUM_W),
    .DEN_W (RECENT_N_W)
  ) u_rdiv (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (rsum),
    .den   (rn),
    .done  (rdiv_done),
    .quo   (rquo)
  );

`ifndef SYNTHESIS
  a_done_in_wait: assert property (@(posedge clk) disable iff (rst)
    rdiv_done |-> state == ST_DWAIT)
    else $error("divider finished outside the wait state");

  a_fill_only_on_store: assert property (@(posedge clk) disable iff (rst)
    state != ST_DEL |=> $stable(fill))
    else $error("fill count moved outside the store step");

  a_sorted_taps: assert property (@(posedge clk) disable iff (rst)
    sv[TRIM_LOW-1] <= sv[HI_TAP])
    else $error("sorted row out of order");

  a_empty_sum: assert property (@(posedge clk) disable iff (rst)
    fill == '0 |-> rsum == '0 && mid == '0)
    else $error("sums not zero on an empty window");

  a_out_held: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(trimmed_mean) && $stable(stored_count))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire

[sv/hrwf_sort_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module hrwf_sort_cell (
  input  wire                       clk,
  input  wire                       rst,
  input  wire hrwf_pkg::cell_ctrl_t ctrl,
  input  wire hrwf_pkg::sample_t    prev_val,
  input  wire hrwf_pkg::sample_t    next_val,
  output hrwf_pkg::sample_t         val
);
  import hrwf_pkg::*;

  // delete: cells at or above the key pull from above
  // insert: cells above the key push up, the boundary cell takes the key
  always_ff @(posedge clk) begin
    if (rst) begin
      val <= '0;
    end else begin
      case (ctrl.op)
        OP_DEL: begin
          if (val >= ctrl.key) val <= next_val;
        end
        OP_INS: begin
          if (val > ctrl.key) val <= (prev_val <= ctrl.key) ? ctrl.key : prev_val;
        end
        OP_HOLD: begin
          val <= val;
        end
        default: begin
          val <= val;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

[sv/hrwf_div.sv]
`timescale 1ns / 1ps
`default_nettype none

module hrwf_div #(
  parameter int NUM_W = 16,
  parameter int DEN_W = 8
) (
  input  wire                          clk,
  input  wire                          rst,
  input  wire                          start,
  input  wire  [NUM_W-1:0]             num,
  input  wire  [DEN_W-1:0]             den,
  output logic                         done,
  output logic [hrwf_pkg::QUO_W-1:0]   quo
);
  import hrwf_pkg::*;

  localparam int DSH_W = DEN_W + QUO_W;
  localparam int CMP_W = NUM_W + DSH_W;

  logic [NUM_W-1:0]     rem;
  logic [DSH_W-1:0]     dsh;
  logic [DIV_CNT_W-1:0] cnt;
  logic                 run;

  logic [CMP_W-1:0] rem_in, dsh_in, r1, d1, r0;
  logic [QUO_W-1:0] q_in;
  logic             b1, b0;

  // two quotient bits per cycle; quotient is known to fit in QUO_W bits
  always_comb begin
    rem_in = start ? CMP_W'(num) : CMP_W'(rem);
    dsh_in = start ? (CMP_W'(den) << (QUO_W - 1)) : CMP_W'(dsh);
    q_in   = start ? '0 : quo;
    b1     = rem_in >= dsh_in;
    r1     = b1 ? rem_in - dsh_in : rem_in;
    d1     = dsh_in >> 1;
    b0     = r1 >= d1;
    r0     = b0 ? r1 - d1 : r1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= DIV_CNT_W'(1);
      end else if (run) begin
        cnt <= cnt + 1'b1;
        if (cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start || run) begin
      rem <= NUM_W'(r0);
      dsh <= DSH_W'(d1 >> 1);
      quo <= {q_in[QUO_W-3:0], b1, b0};
    end
  end

endmodule

`default_nettype wire

[tb/heart_rate_window_filter_tb.sv]
`timescale 1ns / 1ps

module heart_rate_window_filter_tb;
  import hrwf_pkg::*;

  localparam int WIN = 64;
  localparam int N_RANDOM = 850;

  typedef sample_t window_t [WIN];

  typedef struct {
    sample_t     bpm;
    logic        active;
  } hr_reading_t;

  typedef struct {
    sample_t             max_rate;
    sample_t             recent_average;
    sample_t             trimmed_mean;
    logic [COUNT_W-1:0]  stored_count;
  } rate_summary_t;

  typedef enum {SHAPE_WIDE, SHAPE_FLAT, SHAPE_PHYSIO, SHAPE_RAIL} stim_shape_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         sample = 8'd0;
  logic               sensor_active = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [7:0]         max_rate;
  logic [7:0]         recent_average;
  logic [7:0]         trimmed_mean;
  logic [COUNT_W-1:0] stored_count;

  // predictor state, arrival order
  sample_t win_q [WIN];
  int unsigned fill_n = 0;
  sample_t peak = '0;

  hr_reading_t   readings_q[$];
  rate_summary_t summary_q[$];

  // handshake flags, set at the rising edge and read at the falling edge
  bit in_xfer = 1'b0;
  bit out_xfer = 1'b0;

  bit in_busy = 1'b0;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int in_gap = 0;
  int stall_left = 0;

  int fails = 0;
  int n_in = 0;
  int n_idle = 0;
  int n_out = 0;
  int n_slide = 0;

  heart_rate_window_filter #(
    .WINDOW_SIZE(WIN)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .sensor_active(sensor_active),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .max_rate(max_rate),
    .recent_average(recent_average),
    .trimmed_mean(trimmed_mean),
    .stored_count(stored_count)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic sample_t trimmed_window_mean(input window_t w);
    window_t     s;
    sample_t     v;
    int          j;
    int unsigned sum;
    s = w;
    for (int i = 1; i < WIN; i++) begin
      v = s[i];
      j = i;
      while (j > 0 && s[j-1] > v) begin
        s[j] = s[j-1];
        j--;
      end
      s[j] = v;
    end
    sum = 0;
    for (int i = TRIM_LOW; i < WIN - TRIM_HIGH; i++) sum += s[i];
    return sample_t'(sum / (WIN - TRIM_LOW - TRIM_HIGH));
  endfunction

  function automatic rate_summary_t step_window(input sample_t bpm, input logic active);
    rate_summary_t r;
    int unsigned   n;
    int unsigned   sum;
    if (bpm > peak) peak = bpm;
    if (fill_n == 0) begin
      if (active) begin
        win_q[0] = bpm;
        fill_n = 1;
      end
    end else if (fill_n < WIN) begin
      win_q[fill_n] = bpm;
      fill_n++;
    end else begin
      for (int i = 0; i < WIN - 1; i++) win_q[i] = win_q[i+1];
      win_q[WIN-1] = bpm;
    end
    n = (fill_n < RECENT_LEN) ? fill_n : RECENT_LEN;
    sum = 0;
    for (int unsigned i = fill_n - n; i < fill_n; i++) sum += win_q[i];
    r.max_rate = peak;
    r.recent_average = (n == 0) ? '0 : sample_t'(sum / n);
    r.trimmed_mean = trimmed_window_mean(win_q);
    r.stored_count = fill_n[COUNT_W-1:0];
    return r;
  endfunction

  // predict on each input transfer, check each output transfer
  always @(posedge clk) begin : monitor
    rate_summary_t want;
    in_xfer = !rst && in_valid && !in_stall;
    out_xfer = !rst && out_valid && !out_stall;
    if (in_xfer) begin
      summary_q.push_back(step_window(sample, sensor_active));
      n_in++;
      if (!sensor_active) n_idle++;
      if (fill_n == WIN) n_slide++;
    end
    if (out_xfer) begin
      n_out++;
      if (summary_q.size() == 0) begin
        fails++;
        if (fails <= 10)
          $display("%0t: result with none pending: max %0d avg %0d trim %0d count %0d",
                   $time, max_rate, recent_average, trimmed_mean, stored_count);
      end else begin
        want = summary_q.pop_front();
        if (max_rate !== want.max_rate || recent_average !== want.recent_average ||
            trimmed_mean !== want.trimmed_mean || stored_count !== want.stored_count) begin
          fails++;
          if (fails <= 10)
            $display("%0t: result %0d: exp max %0d avg %0d trim %0d count %0d, got %0d %0d %0d %0d",
                     $time, n_out, want.max_rate, want.recent_average, want.trimmed_mean,
                     want.stored_count, max_rate, recent_average, trimmed_mean,
                     stored_count);
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    hr_reading_t rd;
    if (!rst) begin
      if (in_xfer) begin
        in_busy = 1'b0;
        if ($urandom_range(0, 39) == 0) in_burst = !in_burst;
        in_gap = in_burst ? 0 : $urandom_range(0, 4);
      end
      if (!in_busy) begin
        if (in_gap > 0) begin
          in_gap--;
        end else if (readings_q.size() > 0) begin
          rd = readings_q.pop_front();
          in_busy = 1'b1;
          sample <= rd.bpm;
          sensor_active <= rd.active;
        end
      end
      in_valid <= in_busy;
    end
  end

  // receiver: a fresh stall length for every result
  always @(negedge clk) begin : receiver
    if (!rst) begin
      if (out_xfer) begin
        if ($urandom_range(0, 39) == 0) out_burst = !out_burst;
        stall_left = out_burst ? 0 : $urandom_range(0, 4);
      end
      out_stall <= (stall_left > 0);
      if (out_valid === 1'b1 && stall_left > 0) stall_left--;
    end
  end

  initial begin : stimulus
    hr_reading_t rd;
    stim_shape_t shape;
    int          run_left;
    sample_t     level;
    sample_t     directed_bpm [16];
    bit          directed_act [16];

    // empty window with the sensor idle first, then the first store,
    // then the rails and alternating bit patterns
    directed_bpm = '{8'd0, 8'd37, 8'd100, 8'd150, 8'd200, 8'd1, 8'd0, 8'd254,
                     8'd255, 8'd128, 8'd127, 8'h55, 8'hAA, 8'd0, 8'd255, 8'd60};
    directed_act = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
                     1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1};
    for (int k = 0; k < 16; k++) begin
      rd.bpm = directed_bpm[k];
      rd.active = directed_act[k];
      readings_q.push_back(rd);
    end

    run_left = 0;
    shape = SHAPE_WIDE;
    level = 8'd70;
    for (int k = 0; k < N_RANDOM; k++) begin
      if (run_left == 0) begin
        case ($urandom_range(0, 3))
          0: shape = SHAPE_WIDE;
          1: shape = SHAPE_FLAT;
          2: shape = SHAPE_PHYSIO;
          default: shape = SHAPE_RAIL;
        endcase
        run_left = $urandom_range(5, 60);
        level = sample_t'($urandom_range(40, 200));
      end
      run_left--;
      case (shape)
        SHAPE_WIDE: rd.bpm = sample_t'($urandom_range(0, 255));
        SHAPE_FLAT: rd.bpm = level;   // long ties through the sort
        SHAPE_PHYSIO: rd.bpm = sample_t'($urandom_range(40, 200));
        default: rd.bpm = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      endcase
      rd.active = 1'($urandom_range(0, 1));
      readings_q.push_back(rd);
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (readings_q.size() > 0 || in_busy || summary_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Drove %0d samples (%0d with sensor idle), checked %0d results,",
             n_in, n_idle, n_out);
    $display("window full for %0d transfers; %0d mismatches", n_slide, fails);
    if (fails == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  initial begin : watchdog
    #400000;
    $display("Timeout with %0d results outstanding", summary_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
